/* hw/rtl/sorted_set_merge_macros.svh */
// Assertion macros for the sorted set merge RTL.
`ifndef SORTED_SET_MERGE_MACROS_SVH
`define SORTED_SET_MERGE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SSM_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_set_merge check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SSM_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_set_merge check failed");

`endif

/* hw/rtl/ssm_pkg.sv */
// Shared constants and types for the sorted set merge block.
package ssm_pkg;

   localparam int SSM_LIST_DEPTH  = 16;
   localparam int SSM_MAX_RESULTS = 32;
   localparam int SSM_ELEM_W      = 32;

   // load side -> merge sequencer
   typedef struct packed {
      logic start;
      logic mode;
      logic ovf;
   } ssm_ctrl_type;

   // merge sequencer -> load side
   typedef struct packed {
      logic busy;
      logic finish;
   } ssm_stat_type;

endpackage

/* hw/rtl/ssm_list_mem.sv */
// Single-write, single-read list storage with registered read data.
module ssm_list_mem
   import ssm_pkg::*;
#(
   parameter int LIST_DEPTH = SSM_LIST_DEPTH,
   localparam int AW = $clog2(LIST_DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [SSM_ELEM_W-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [SSM_ELEM_W-1:0] rd_data
);

   logic [SSM_ELEM_W-1:0] mem [LIST_DEPTH];
   logic [SSM_ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ssm_merge_seq.sv */
// Two-pointer merge sequencer around one shared comparator, with the result register.
module ssm_merge_seq
   import ssm_pkg::*;
#(
   parameter int LIST_DEPTH = SSM_LIST_DEPTH,
   localparam int AW = $clog2(LIST_DEPTH),
   localparam int CW = $clog2(LIST_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ssm_ctrl_type          ctrl,
   input  logic [CW-1:0]         cnt_a,
   input  logic [CW-1:0]         cnt_b,
   input  logic [SSM_ELEM_W-1:0] rd_a,
   input  logic [SSM_ELEM_W-1:0] rd_b,
   output logic [AW-1:0]         addr_a,
   output logic [AW-1:0]         addr_b,
   output ssm_stat_type          stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SSM_ELEM_W-1:0] rsp_member,
   output logic                  rsp_run_end,
   output logic                  rsp_none_found,
   output logic                  rsp_overflowed
);

   `include "sorted_set_merge_macros.svh"

   localparam int NW = $clog2(SSM_MAX_RESULTS + 1);
   localparam logic [NW-1:0] CAP_LAST = NW'(SSM_MAX_RESULTS - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         i_ff, i_in, j_ff, j_in;
   logic [CW-1:0]         ca_ff, ca_in, cb_ff, cb_in;
   logic                  mode_ff, mode_in, ovf_ff, ovf_in;
   logic [SSM_ELEM_W-1:0] pend_ff, pend_in;
   logic                  have_pend_ff, have_pend_in;
   logic [NW-1:0]         n_ff, n_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SSM_ELEM_W-1:0] rsp_member_ff, rsp_member_in;
   logic                  rsp_run_end_ff, rsp_run_end_in;
   logic                  rsp_none_ff, rsp_none_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  has_a, has_b, a_lt_b, a_eq_b, out_free;
   logic                  cand_vld, step_end;
   logic [SSM_ELEM_W-1:0] cand;
   logic [CW-1:0]         i_step, j_step;

   // the shared comparator
   assign a_lt_b = rd_a < rd_b;
   assign a_eq_b = rd_a == rd_b;

   assign has_a    = i_ff < ca_ff;
   assign has_b    = j_ff < cb_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // one walk step: candidate word and pointer moves
   always_comb begin
      cand_vld = 1'b0;
      cand     = rd_a;
      step_end = 1'b0;
      i_step   = i_ff;
      j_step   = j_ff;
      if (has_a && has_b) begin
         if (a_lt_b) begin
            i_step   = i_ff + 1'b1;
            cand_vld = mode_ff;
         end else if (a_eq_b) begin
            i_step   = i_ff + 1'b1;
            j_step   = j_ff + 1'b1;
            cand_vld = 1'b1;
         end else begin
            j_step   = j_ff + 1'b1;
            cand     = rd_b;
            cand_vld = mode_ff;
         end
      end else if (mode_ff && has_a) begin
         i_step   = i_ff + 1'b1;
         cand_vld = 1'b1;
      end else if (mode_ff && has_b) begin
         j_step   = j_ff + 1'b1;
         cand     = rd_b;
         cand_vld = 1'b1;
      end else begin
         step_end = 1'b1;
      end
      // union drops a repeat of the last kept word
      if (mode_ff && have_pend_ff && (cand == pend_ff)) begin
         cand_vld = 1'b0;
      end
   end

   always_comb begin
      state_in       = state_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      ca_in          = ca_ff;
      cb_in          = cb_ff;
      mode_in        = mode_ff;
      ovf_in         = ovf_ff;
      pend_in        = pend_ff;
      have_pend_in   = have_pend_ff;
      n_in           = n_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_member_in  = rsp_member_ff;
      rsp_run_end_in = rsp_run_end_ff;
      rsp_none_in    = rsp_none_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               i_in         = '0;
               j_in         = '0;
               ca_in        = cnt_a;
               cb_in        = cnt_b;
               mode_in      = ctrl.mode;
               ovf_in       = ctrl.ovf;
               have_pend_in = 1'b0;
               n_in         = '0;
               state_in     = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (step_end) begin
               state_in = S_FLUSH;
            end else if (!(cand_vld && have_pend_ff && !out_free)) begin
               i_in     = i_step;
               j_in     = j_step;
               state_in = S_FETCH;
               if (cand_vld) begin
                  if (have_pend_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_member_in  = pend_ff;
                     rsp_run_end_in = 1'b0;
                     rsp_none_in    = 1'b0;
                     rsp_ovf_in     = ovf_ff;
                  end
                  pend_in      = cand;
                  have_pend_in = 1'b1;
                  n_in         = n_ff + 1'b1;
                  if (n_ff == CAP_LAST) begin
                     state_in = S_FLUSH;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_member_in  = have_pend_ff ? pend_ff : '0;
               rsp_run_end_in = 1'b1;
               rsp_none_in    = !have_pend_ff;
               rsp_ovf_in     = ovf_ff;
               have_pend_in   = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_pend_ff <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_pend_ff <= have_pend_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      ca_ff          <= ca_in;
      cb_ff          <= cb_in;
      mode_ff        <= mode_in;
      ovf_ff         <= ovf_in;
      pend_ff        <= pend_in;
      rsp_member_ff  <= rsp_member_in;
      rsp_run_end_ff <= rsp_run_end_in;
      rsp_none_ff    <= rsp_none_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign addr_a         = i_ff[AW-1:0];
   assign addr_b         = j_ff[AW-1:0];
   assign stat.busy      = state_ff != S_IDLE;
   assign stat.finish    = (state_ff == S_FLUSH) && out_free;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_member     = rsp_member_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_none_found = rsp_none_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   `SSM_CHECK_NEXT(a_start_fetch, ctrl.start && (state_ff == S_IDLE), state_ff == S_FETCH)
   `SSM_CHECK(a_ptr_bound, state_ff == S_EVAL, (i_ff <= ca_ff) && (j_ff <= cb_ff))
   `SSM_CHECK(a_cap, have_pend_ff, (n_ff != '0) && (n_ff <= NW'(SSM_MAX_RESULTS)))
   `SSM_CHECK_NEXT(a_flush_done, stat.finish, (state_ff == S_IDLE) && rsp_run_end_ff)

endmodule

/* hw/rtl/sorted_set_merge.sv */
// Top level of the sorted set merge block: list loading, mode register, merge sequencer.
//
// Usage:
//   req_* channel carries list words: req_which_list picks list A (0) or B (1),
//   req_is_final closes a list after storing req_element, req_list_empty closes
//   it without storing. A word is taken when req_valid is high and req_stall low.
//   Loading takes one word per cycle while req_stall is low. A word for a list already closed is dropped;
//   a word past LIST_DEPTH is dropped and sets the overflow flag for the run.
//   The word that closes the second list starts the merge; req_stall stays high
//   until the final result word is in the output register.
//   Merge: each walk step is a registered memory read, then the one shared
//   comparator; at most count_a + count_b steps, plus one step to see the end
//   and a flush state that sends the final result word.
//   rsp_* channel gives the set words in order; the last has rsp_run_end set,
//   an empty set gives one word with rsp_none_found. At most 32 words per run.
//   rsp_stall holds the output register and pauses the walk; nothing is lost.
//   csr_write_enable writes the mode (0 intersection, 1 union); write it only
//   while idle. Synchronous reset clears counts, flags, mode and both channels.
module sorted_set_merge
   import ssm_pkg::*;
#(
   parameter int LIST_DEPTH = SSM_LIST_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_which_list,
   input  logic [SSM_ELEM_W-1:0] req_element,
   input  logic                  req_is_final,
   input  logic                  req_list_empty,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SSM_ELEM_W-1:0] rsp_member,
   output logic                  rsp_run_end,
   output logic                  rsp_none_found,
   output logic                  rsp_overflowed,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   logic [CW-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic          a_done_ff, a_done_in, b_done_ff, b_done_in;
   logic          ovf_ff, ovf_in;
   logic          mode_ff;

   logic          accept, take, store_en, ovf_set, closes;
   logic          sel_done;
   logic [CW-1:0] sel_cnt;
   logic [AW-1:0] addr_a, addr_b;
   logic [SSM_ELEM_W-1:0] rd_a, rd_b;
   ssm_ctrl_type  ctrl;
   ssm_stat_type  stat;

   assign req_stall = stat.busy;
   assign accept    = req_valid && !req_stall;

   assign sel_done = req_which_list ? b_done_ff : a_done_ff;
   assign sel_cnt  = req_which_list ? count_b_ff : count_a_ff;
   assign take     = accept && !sel_done;
   // full list: word dropped, flag raised, final mark still honored
   assign store_en = take && !req_list_empty && (sel_cnt < DEPTH_C);
   assign ovf_set  = take && !req_list_empty && (sel_cnt >= DEPTH_C);
   assign closes   = take && (req_list_empty || req_is_final);

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      if (store_en && !req_which_list) begin
         count_a_in = count_a_ff + 1'b1;
      end
      if (store_en && req_which_list) begin
         count_b_in = count_b_ff + 1'b1;
      end
      a_done_in = a_done_ff || (closes && !req_which_list);
      b_done_in = b_done_ff || (closes && req_which_list);
      ovf_in    = ovf_ff || ovf_set;
   end

   // both lists closed: hand the counts to the sequencer, clear load state
   assign ctrl.start = take && a_done_in && b_done_in;
   assign ctrl.mode  = mode_ff;
   assign ctrl.ovf   = ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
         a_done_ff  <= 1'b0;
         b_done_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
         mode_ff    <= 1'b0;
      end else begin
         if (ctrl.start) begin
            count_a_ff <= '0;
            count_b_ff <= '0;
            a_done_ff  <= 1'b0;
            b_done_ff  <= 1'b0;
            ovf_ff     <= 1'b0;
         end else begin
            count_a_ff <= count_a_in;
            count_b_ff <= count_b_in;
            a_done_ff  <= a_done_in;
            b_done_ff  <= b_done_in;
            ovf_ff     <= ovf_in;
         end
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   ssm_list_mem #(.LIST_DEPTH(LIST_DEPTH)) u_mem_a (
      .clock   (clock),
      .wr_en   (store_en && !req_which_list),
      .wr_addr (sel_cnt[AW-1:0]),
      .wr_data (req_element),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   ssm_list_mem #(.LIST_DEPTH(LIST_DEPTH)) u_mem_b (
      .clock   (clock),
      .wr_en   (store_en && req_which_list),
      .wr_addr (sel_cnt[AW-1:0]),
      .wr_data (req_element),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   ssm_merge_seq #(.LIST_DEPTH(LIST_DEPTH)) u_merge (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .cnt_a          (count_a_in),
      .cnt_b          (count_b_in),
      .rd_a           (rd_a),
      .rd_b           (rd_b),
      .addr_a         (addr_a),
      .addr_b         (addr_b),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_member     (rsp_member),
      .rsp_run_end    (rsp_run_end),
      .rsp_none_found (rsp_none_found),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule
